FILE: rtl/spv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spv_pkg
// shared types, codes and default sizes of the sample playback voice
// ----------------------------------------------------------------------------
package spv_pkg;

    // default store size and position fraction
    localparam int WAVE_DEPTH_DEF = 4096;
    localparam int FRAC_BITS_DEF  = 16;

    // fixed field widths
    localparam int KIND_W     = 2;
    localparam int CMD_W      = 3;
    localparam int SEEK_W     = 28;
    localparam int LOAD_ADR_W = 12;
    localparam int SAMPLE_W   = 16;
    localparam int FRAME_W    = 2 * SAMPLE_W;

    // configuration registers
    localparam int FREQ_W     = 24;
    localparam int WLEN_W     = 13;
    localparam int CFG_DATA_W = FREQ_W;
    localparam logic [FREQ_W-1:0] FREQ_RESET = 24'd65536;

    typedef enum logic [0:0] {
        CFG_FREQ_RATIO  = 1'b0,
        CFG_WAVE_LENGTH = 1'b1
    } t_cfg_index;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 2'd0,
        KIND_COMMAND = 2'd1,
        KIND_SEEK    = 2'd2,
        KIND_LOAD    = 2'd3
    } t_kind;

    typedef enum logic [CMD_W-1:0] {
        CMD_PLAY    = 3'd0,
        CMD_STOP    = 3'd1,
        CMD_PAUSE   = 3'd2,
        CMD_LOOP    = 3'd3,
        CMD_REVERSE = 3'd4
    } t_command;

    typedef enum logic [4:0] {
        MODE_STOPPED = 5'b00001,
        MODE_PLAYING = 5'b00010,
        MODE_PAUSED  = 5'b00100,
        MODE_LOOPED  = 5'b01000,
        MODE_REVERSE = 5'b10000
    } t_mode;

endpackage
`default_nettype wire

FILE: rtl/spv_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spv interfaces
// request channel into the voice and frame channel out of it
// ----------------------------------------------------------------------------
interface spv_item_if
    import spv_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic [CMD_W-1:0]           command;
    logic [SEEK_W-1:0]          seek_position;
    logic [LOAD_ADR_W-1:0]      load_address;
    logic signed [SAMPLE_W-1:0] load_left;
    logic signed [SAMPLE_W-1:0] load_right;

    modport source (
        output valid, kind, command, seek_position, load_address, load_left, load_right,
        input  ready
    );
    modport sink (
        input  valid, kind, command, seek_position, load_address, load_left, load_right,
        output ready
    );
endinterface

interface spv_frame_if
    import spv_pkg::*;
;
    logic                       valid;
    logic                       ready;
    logic                       frame_valid;
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;

    modport source (
        output valid, frame_valid, out_left, out_right,
        input  ready
    );
    modport sink (
        input  valid, frame_valid, out_left, out_right,
        output ready
    );
endinterface
`default_nettype wire

FILE: rtl/spv_wave_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spv_wave_ram
// stereo frame store, one write and one registered read port
// ----------------------------------------------------------------------------
module spv_wave_ram
    import spv_pkg::*;
#(
    parameter int DEPTH  = WAVE_DEPTH_DEF,
    parameter int ADDR_W = $clog2(WAVE_DEPTH_DEF)
) (
    input  wire logic               i_clk,
    input  wire logic               i_wr_en,
    input  wire logic [ADDR_W-1:0]  i_wr_addr,
    input  wire logic [FRAME_W-1:0] i_wr_data,
    input  wire logic               i_rd_en,
    input  wire logic [ADDR_W-1:0]  i_rd_addr,
    output logic      [FRAME_W-1:0] o_rd_data
);

    logic [FRAME_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/sample_playback_voice.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sample_playback_voice
// stereo sample player with play, loop, reverse, pause, stop and seek
// ----------------------------------------------------------------------------
// The voice takes one request per clock while ready is high: tick, command,
// seek or load. Loads write a stereo frame into the wave store; commands set
// the mode; seek loads a 12.16 value into the position. Each tick returns
// exactly one frame, flagged valid or silent (silent frames carry zero
// samples). A tick updates the position in the cycle it is accepted (one add
// or subtract and a compare on the position register) and reads the store at
// the same edge; the frame then passes the store read register and the
// output register, a two-deep pipeline, so ready only drops when both hold a
// frame and the sink is stalling. A tick right after a load to the same
// address sees the new frame. The store has no reset; the user must write
// configuration only while the voice is idle; the voice does not enforce it.
// ----------------------------------------------------------------------------
module sample_playback_voice
    import spv_pkg::*;
#(
    parameter int WAVE_DEPTH = WAVE_DEPTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire t_cfg_index            i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    spv_item_if.sink                   i_item,
    spv_frame_if.source                o_frame
);

    localparam int ADDR_W = $clog2(WAVE_DEPTH);
    localparam int LEN_W  = ADDR_W + 1;
    localparam int INT_W  = ADDR_W + FRAC_BITS;
    // room for a seek value and for end of wave plus one step
    localparam int POS_W  = ((INT_W > SEEK_W) ? INT_W : SEEK_W) + 1;

    // configuration
    logic [FREQ_W-1:0] r_freq_ratio;
    logic [WLEN_W-1:0] r_wave_length;

    // voice state
    t_mode             r_mode, n_mode;
    logic [POS_W-1:0]  r_pos, n_pos;

    // pipeline: store read stage, then output register
    logic               r_s1_valid;
    logic               r_s1_emit;
    logic [FRAME_W-1:0] rd_data;
    logic               r_o_valid;
    logic               r_o_frame_valid;
    logic [SAMPLE_W-1:0] r_o_left;
    logic [SAMPLE_W-1:0] r_o_right;

    logic s1_move, s1_free, acc, tick_acc, tick_emit;
    logic [LEN_W-1:0]  len;
    logic [POS_W-1:0]  end_pos, step, rd_base;
    logic [ADDR_W-1:0] rd_addr;
    logic [31:0]       load_addr_ext;
    logic              wr_en;

    // handshake: the read stage frees up when it moves into the output register
    assign s1_move  = r_s1_valid && (!r_o_valid || o_frame.ready);
    assign s1_free  = !r_s1_valid || s1_move;
    assign i_item.ready = s1_free;
    assign acc      = i_item.valid && s1_free;
    assign tick_acc = acc && (i_item.kind == KIND_TICK);

    // usable wave length, capped at the store depth
    always_comb begin
        if (32'(r_wave_length) > WAVE_DEPTH) begin
            len = LEN_W'(WAVE_DEPTH);
        end else begin
            len = LEN_W'(r_wave_length);
        end
    end

    assign end_pos = POS_W'(len) << FRAC_BITS;
    assign step    = POS_W'(r_freq_ratio);

    // next mode and position, and the store address a tick reads
    always_comb begin
        n_mode    = r_mode;
        n_pos     = r_pos;
        rd_base   = r_pos;
        tick_emit = 1'b0;
        if (acc) begin
            case (i_item.kind)
                KIND_COMMAND: begin
                    case (i_item.command)
                        CMD_PLAY:    n_mode = MODE_PLAYING;
                        CMD_STOP: begin
                            n_mode = MODE_STOPPED;
                            n_pos  = '0;
                        end
                        CMD_PAUSE:   n_mode = MODE_PAUSED;
                        CMD_LOOP:    n_mode = MODE_LOOPED;
                        CMD_REVERSE: n_mode = MODE_REVERSE;
                        default:     ;  // unused command codes do nothing
                    endcase
                end
                KIND_SEEK: begin
                    n_pos = POS_W'(i_item.seek_position);
                end
                KIND_TICK: begin
                    // an empty wave renders silence and holds the position
                    if (len != '0) begin
                        case (r_mode)
                            MODE_PLAYING: begin
                                if (r_pos < end_pos) begin
                                    tick_emit = 1'b1;
                                    n_pos     = r_pos + step;
                                end
                            end
                            MODE_LOOPED: begin
                                // wrap to the start once past the end
                                if (r_pos >= end_pos) begin
                                    rd_base = '0;
                                end
                                tick_emit = 1'b1;
                                n_pos     = rd_base + step;
                            end
                            MODE_REVERSE: begin
                                // past the end still steps down, but silent
                                if (r_pos != '0) begin
                                    tick_emit = (r_pos < end_pos);
                                    n_pos     = (r_pos > step) ? (r_pos - step) : '0;
                                end
                            end
                            default: ;  // stopped or paused: silence, hold
                        endcase
                    end
                end
                default: ;  // load goes straight to the store
            endcase
        end
    end

    assign rd_addr = rd_base[FRAC_BITS +: ADDR_W];

    // loads beyond the store are dropped
    assign load_addr_ext = 32'(i_item.load_address);
    assign wr_en = acc && (i_item.kind == KIND_LOAD) && (load_addr_ext < WAVE_DEPTH);

    spv_wave_ram #(
        .DEPTH  (WAVE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_wave_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (load_addr_ext[ADDR_W-1:0]),
        .i_wr_data ({i_item.load_right, i_item.load_left}),
        .i_rd_en   (tick_acc),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq_ratio  <= FREQ_RESET;
            r_wave_length <= '0;
            r_mode        <= MODE_STOPPED;
            r_pos         <= '0;
            r_s1_valid    <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            r_mode <= n_mode;
            r_pos  <= n_pos;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FREQ_RATIO:  r_freq_ratio  <= i_cfg_data[FREQ_W-1:0];
                    CFG_WAVE_LENGTH: r_wave_length <= i_cfg_data[WLEN_W-1:0];
                    default:         ;
                endcase
            end
            if (s1_free) begin
                r_s1_valid <= tick_acc;
            end
            if (s1_move) begin
                r_o_valid <= 1'b1;
            end else if (o_frame.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            r_s1_emit <= tick_emit;
        end
        if (s1_move) begin
            r_o_frame_valid <= r_s1_emit;
            r_o_left        <= r_s1_emit ? rd_data[SAMPLE_W-1:0] : '0;
            r_o_right       <= r_s1_emit ? rd_data[FRAME_W-1:SAMPLE_W] : '0;
        end
    end

    assign o_frame.valid       = r_o_valid;
    assign o_frame.frame_valid = r_o_frame_valid;
    assign o_frame.out_left    = r_o_left;
    assign o_frame.out_right   = r_o_right;

`ifndef SYNTHESIS
    // a stalled read stage keeps its frame
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_move) |=> (r_s1_valid && $stable(rd_data)))
        else $error("read stage lost its frame while stalled");

    // every accepted tick reaches the read stage
    a_tick_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc |=> r_s1_valid)
        else $error("accepted tick did not enter the read stage");

    // silent frames carry zero samples
    a_silence_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_frame.valid && !o_frame.frame_valid) |->
            (o_frame.out_left == '0 && o_frame.out_right == '0))
        else $error("silent frame with nonzero samples");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_sample_playback_voice.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sample_playback_voice
// self-checking bench for the stereo sample playback voice: requests come
// from a queue through a clocked driver, every accepted request runs through
// a cycle-free predictor of the voice, and a clocked monitor checks each
// returned frame against the oldest predicted one
// ----------------------------------------------------------------------------
module tb_sample_playback_voice;
    import spv_pkg::*;

    localparam int WAVE_DEPTH   = WAVE_DEPTH_DEF;
    localparam int FRAC_BITS    = FRAC_BITS_DEF;
    localparam int QUIET_LIMIT  = 2000;   // cycles with no handshake at all
    localparam int DRAIN_CYCLES = 6;      // two-stage frame pipe plus margin
    localparam int HOLD_CYCLES  = 60;     // long sink hold-off to back up the voice
    localparam int MAX_PRINTS   = 20;

    localparam logic [CMD_W-1:0]    CMD_UNUSED_LO = CMD_W'(CMD_REVERSE + 1);
    localparam logic [CMD_W-1:0]    CMD_UNUSED_HI = '1;
    localparam logic [SEEK_W-1:0]   SEEK_MAX      = '1;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX    = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN    = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct {
        t_kind                 kind;
        logic [CMD_W-1:0]      command;
        logic [SEEK_W-1:0]     seek_position;
        logic [LOAD_ADR_W-1:0] load_address;
        logic [SAMPLE_W-1:0]   load_left;
        logic [SAMPLE_W-1:0]   load_right;
    } t_voice_req;

    typedef struct {
        logic                       audible;
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } t_voice_frame;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_index            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    spv_item_if  req_if ();
    spv_frame_if frame_if ();

    sample_playback_voice DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_item      (req_if),
        .o_frame     (frame_if)
    );

    // request traffic and expected frames
    t_voice_req   pending_requests[$];
    t_voice_frame pending_frames[$];
    t_voice_req   offered;
    int           n_pushed, n_accepted, n_errors;
    int           n_ticks, n_audible, n_loads, n_settings;

    // generator view of which store entries hold data; ticks never read past it
    bit filled [WAVE_DEPTH];

    // knobs the stimulus process turns between phases
    int unsigned send_idle_pct, recv_idle_pct;
    bit          pressure_on;

    // receiver hold-off bookkeeping, owned by the receiver process
    int hold_left;
    bit hold_done;

    // predictor state: own copy of registers, mode, position and store
    logic [FREQ_W-1:0]   step_reg;
    logic [WLEN_W-1:0]   length_reg;
    t_mode               play_mode;
    logic [63:0]         play_pos;
    logic [FRAME_W-1:0]  wave_copy [WAVE_DEPTH];

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic t_voice_frame stored_frame(input logic [63:0] idx);
        t_voice_frame f;
        f.audible = 1'b1;
        f.left    = wave_copy[idx[LOAD_ADR_W-1:0]][SAMPLE_W-1:0];
        f.right   = wave_copy[idx[LOAD_ADR_W-1:0]][FRAME_W-1:SAMPLE_W];
        return f;
    endfunction

    function automatic void voice_step(input t_voice_req r);
        t_voice_frame f;
        logic [63:0]  span;
        logic [63:0]  end_pos;
        logic [63:0]  idx;
        case (r.kind)
            KIND_COMMAND: begin
                case (r.command)
                    CMD_PLAY:    play_mode = MODE_PLAYING;
                    CMD_STOP: begin
                        play_mode = MODE_STOPPED;
                        play_pos  = '0;
                    end
                    CMD_PAUSE:   play_mode = MODE_PAUSED;
                    CMD_LOOP:    play_mode = MODE_LOOPED;
                    CMD_REVERSE: play_mode = MODE_REVERSE;
                    default: ;  // unused codes leave the mode alone
                endcase
            end
            KIND_SEEK: play_pos = 64'(r.seek_position);
            KIND_LOAD: begin
                wave_copy[r.load_address] = {r.load_right, r.load_left};
                n_loads++;
            end
            default: begin
                // tick: silence unless the mode renders a frame
                f.audible = 1'b0;
                f.left    = '0;
                f.right   = '0;
                span      = (length_reg > WAVE_DEPTH) ? 64'(WAVE_DEPTH) : 64'(length_reg);
                end_pos   = span << FRAC_BITS;
                n_ticks++;
                if (span != 0) begin
                    case (play_mode)
                        MODE_PLAYING: begin
                            if (play_pos < end_pos) begin
                                f        = stored_frame(play_pos >> FRAC_BITS);
                                play_pos = play_pos + 64'(step_reg);
                            end
                        end
                        MODE_LOOPED: begin
                            if (play_pos >= end_pos) play_pos = '0;
                            f        = stored_frame(play_pos >> FRAC_BITS);
                            play_pos = play_pos + 64'(step_reg);
                        end
                        MODE_REVERSE: begin
                            // past the end stays silent but still walks back
                            if (play_pos != 0) begin
                                idx = play_pos >> FRAC_BITS;
                                if (idx < span) f = stored_frame(idx);
                                play_pos = (play_pos > 64'(step_reg)) ?
                                           play_pos - 64'(step_reg) : '0;
                            end
                        end
                        default: ;  // stopped or paused hold the position
                    endcase
                end
                pending_frames.push_back(f);
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // request driver: offers queued requests, predicts each one accepted
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                voice_step(offered);
                n_accepted++;
            end
            if (!req_if.valid || req_if.ready) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered               = pending_requests.pop_front();
                    req_if.valid         <= 1'b1;
                    req_if.kind          <= offered.kind;
                    req_if.command       <= offered.command;
                    req_if.seek_position <= offered.seek_position;
                    req_if.load_address  <= offered.load_address;
                    req_if.load_left     <= offered.load_left;
                    req_if.load_right    <= offered.load_right;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // frame receiver: random stalls plus one long hold-off when asked
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : receiver
        if (!i_rst_n) begin
            frame_if.ready <= 1'b0;
        end else begin
            if (pressure_on && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                frame_if.ready <= 1'b0;
            end else begin
                frame_if.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        n_errors++;
        if (n_errors <= MAX_PRINTS)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // frame monitor: every accepted frame against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_voice_frame want;
        if (i_rst_n && frame_if.valid && frame_if.ready) begin
            if (pending_frames.size() == 0) begin
                report_mismatch("frame with no tick pending", 1, 0);
            end else begin
                want = pending_frames.pop_front();
                if (want.audible) n_audible++;
                if (frame_if.frame_valid !== want.audible)
                    report_mismatch("frame_valid", longint'(frame_if.frame_valid),
                                    longint'(want.audible));
                if (frame_if.out_left !== want.left)
                    report_mismatch("out_left", longint'(frame_if.out_left),
                                    longint'(want.left));
                if (frame_if.out_right !== want.right)
                    report_mismatch("out_right", longint'(frame_if.out_right),
                                    longint'(want.right));
            end
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: ends the run when nothing moves for too long
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (frame_if.valid && frame_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[%0t] timeout: no request or frame moved for %0d cycles", $time, QUIET_LIMIT);
        $display("sample_playback_voice test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // request builders; fields a kind does not use carry random noise
    // ------------------------------------------------------------------------
    task automatic push_req(input t_kind k, input logic [CMD_W-1:0] c,
                            input logic [SEEK_W-1:0] s, input logic [LOAD_ADR_W-1:0] a,
                            input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r);
        t_voice_req q;
        q.kind          = k;
        q.command       = c;
        q.seek_position = s;
        q.load_address  = a;
        q.load_left     = l;
        q.load_right    = r;
        if (k == KIND_LOAD) filled[a] = 1'b1;
        pending_requests.push_back(q);
        n_pushed++;
    endtask

    task automatic push_tick();
        push_req(KIND_TICK, CMD_W'($urandom), SEEK_W'($urandom), LOAD_ADR_W'($urandom),
                 SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    endtask

    task automatic push_cmd(input logic [CMD_W-1:0] c);
        push_req(KIND_COMMAND, c, SEEK_W'($urandom), LOAD_ADR_W'($urandom),
                 SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    endtask

    task automatic push_seek(input logic [SEEK_W-1:0] s);
        push_req(KIND_SEEK, CMD_W'($urandom), s, LOAD_ADR_W'($urandom),
                 SAMPLE_W'($urandom), SAMPLE_W'($urandom));
    endtask

    task automatic push_load(input logic [LOAD_ADR_W-1:0] a, input logic [SAMPLE_W-1:0] l,
                             input logic [SAMPLE_W-1:0] r);
        push_req(KIND_LOAD, CMD_W'($urandom), SEEK_W'($urandom), a, l, r);
    endtask

    // mostly ticks, with commands, seeks into the wave and store writes mixed in
    task automatic push_random(input int span);
        int               roll;
        logic [SEEK_W-1:0] where;
        roll = $urandom_range(99);
        if (roll < 55) begin
            push_tick();
        end else if (roll < 70) begin
            if ($urandom_range(9) == 0)
                push_cmd(CMD_W'($urandom_range(int'(CMD_UNUSED_HI), int'(CMD_UNUSED_LO))));
            else
                push_cmd(CMD_W'($urandom_range(int'(CMD_REVERSE), int'(CMD_PLAY))));
        end else if (roll < 82) begin
            if (span != 0 && $urandom_range(3) != 0)
                where = SEEK_W'($urandom_range((span << FRAC_BITS) - 1));
            else
                where = SEEK_W'($urandom);
            push_seek(where);
        end else begin
            push_load(LOAD_ADR_W'($urandom_range(WAVE_DEPTH - 1)), SAMPLE_W'($urandom),
                      SAMPLE_W'($urandom));
        end
    endtask

    // wait until every request went in and every predicted frame came out
    task automatic drain();
        while (n_accepted != n_pushed || pending_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // register write while the voice is idle; the predictor follows at once
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_FREQ_RATIO) step_reg = val[FREQ_W-1:0];
        else                       length_reg = val[WLEN_W-1:0];
    endtask

    // one random phase: make sure every entry below the length holds data,
    // set the registers, then run a burst of random requests
    task automatic run_phase(input logic [FREQ_W-1:0] step, input logic [WLEN_W-1:0] len,
                             input int count, input bit squeeze);
        int span;
        span = (len > WAVE_DEPTH) ? WAVE_DEPTH : int'(len);
        for (int a = 0; a < span; a++)
            if (!filled[a]) push_load(LOAD_ADR_W'(a), SAMPLE_W'($urandom), SAMPLE_W'($urandom));
        drain();
        write_reg(CFG_FREQ_RATIO, 24'(step));
        write_reg(CFG_WAVE_LENGTH, 24'(len));
        n_settings++;
        repeat (count) push_random(span);
        if (squeeze) pressure_on = 1'b1;
        drain();
    endtask

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        // known levels on every input before the first edge
        i_rst_n                = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = CFG_FREQ_RATIO;
        cfg_data               = '0;
        req_if.valid           = 1'b0;
        req_if.kind            = KIND_TICK;
        req_if.command         = CMD_PLAY;
        req_if.seek_position   = '0;
        req_if.load_address    = '0;
        req_if.load_left       = '0;
        req_if.load_right      = '0;
        frame_if.ready         = 1'b0;
        // sender idles lightly and the sink stalls a lot
        send_idle_pct          = 18;
        recv_idle_pct          = 73;
        pressure_on            = 1'b0;
        hold_left              = 0;
        hold_done              = 1'b0;
        n_pushed               = 0;
        n_accepted             = 0;
        n_errors               = 0;
        n_ticks                = 0;
        n_audible              = 0;
        n_loads                = 0;
        n_settings             = 0;
        step_reg               = FREQ_RESET;
        length_reg             = '0;
        play_mode              = MODE_STOPPED;
        play_pos               = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extreme samples, top address, empty wave after reset
        push_load(LOAD_ADR_W'(0), SAMPLE_MAX, SAMPLE_MIN);
        push_load(LOAD_ADR_W'(1), SAMPLE_MIN, SAMPLE_MAX);
        push_load(LOAD_ADR_W'(2), '0, '1);
        push_load(LOAD_ADR_W'(3), 16'h0001, 16'h5A5A);
        push_load(LOAD_ADR_W'(WAVE_DEPTH - 1), SAMPLE_MAX, SAMPLE_MIN);
        push_cmd(CMD_PLAY);
        push_tick();                    // zero length: silent, position holds
        drain();

        write_reg(CFG_WAVE_LENGTH, 24'd4);
        n_settings++;
        push_tick();
        push_tick();
        push_cmd(CMD_PAUSE);
        push_tick();                    // paused: silent
        push_cmd(CMD_PLAY);
        push_tick();
        push_tick();
        push_tick();                    // ran off the end
        push_cmd(CMD_LOOP);
        push_tick();                    // loop wraps to the start
        push_cmd(CMD_REVERSE);
        push_seek(SEEK_MAX);
        push_tick();                    // reverse past the end: silent, still steps
        push_seek(SEEK_W'((2 << FRAC_BITS) | (1 << (FRAC_BITS - 1))));
        push_tick();
        push_tick();
        push_tick();                    // clamps at zero
        push_tick();                    // zero position in reverse: silent
        push_cmd(CMD_UNUSED_LO);
        push_cmd(CMD_STOP);
        push_cmd(CMD_UNUSED_HI);
        push_seek(SEEK_W'(3 << FRAC_BITS));
        push_tick();                    // still stopped after unused codes
        push_cmd(CMD_PLAY);
        push_tick();                    // the seek made while stopped is kept
        drain();

        // directed: oversized length acts as the full store, only the
        // loaded first and last entries are ever read
        write_reg(CFG_WAVE_LENGTH, '1);
        n_settings++;
        push_seek(SEEK_W'((WAVE_DEPTH - 1) << FRAC_BITS));
        push_tick();                    // last frame of the store
        push_tick();                    // past the capped end: silent
        push_cmd(CMD_LOOP);
        push_tick();                    // wraps to frame zero
        push_seek(SEEK_W'((WAVE_DEPTH - 1) << FRAC_BITS));
        push_tick();
        push_tick();                    // wraps from the last frame
        push_cmd(CMD_REVERSE);
        push_seek(SEEK_MAX);
        push_tick();                    // top of the store is inside the wave
        push_cmd(CMD_STOP);
        push_tick();
        drain();

        // random, sender idles lightly and the sink stalls a lot
        send_idle_pct = 18;
        recv_idle_pct = 73;
        run_phase(FREQ_RESET, 13'd16, 40, 1'b0);
        run_phase(FREQ_W'($urandom_range(3 << FRAC_BITS, 1)),
                  WLEN_W'($urandom_range(64, 1)), 40, 1'b0);
        run_phase(24'd32768, 13'd5, 40, 1'b0);

        // the other way round; zero and largest steps
        send_idle_pct = 73;
        recv_idle_pct = 18;
        run_phase('0, 13'd24, 30, 1'b0);
        run_phase('1, 13'd40, 40, 1'b0);
        run_phase(FREQ_W'($urandom_range(4 << FRAC_BITS, 1)),
                  WLEN_W'($urandom_range(64, 1)), 40, 1'b0);

        // no idling; the first phase also holds the sink off to fill the voice
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(FREQ_RESET, 13'd1, 50, 1'b1);
        run_phase(FREQ_W'($urandom), WLEN_W'($urandom_range(64, 1)), 40, 1'b0);
        run_phase(24'd1, 13'd48, 40, 1'b0);

        if (pending_frames.size() != 0)
            report_mismatch("frames never returned", 0, pending_frames.size());

        $display("run covered %0d requests over %0d register settings: %0d ticks, %0d frames",
                 n_pushed, n_settings, n_ticks, n_audible);
        $display("with sound, %0d store writes, all modes, seeks, an oversized length",
                 n_loads);
        $display("and a long sink hold-off");
        if (n_errors == 0)
            $display("sample_playback_voice test passed");
        else
            $display("sample_playback_voice test failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/spv_pkg.sv
rtl/spv_if.sv
rtl/spv_wave_ram.sv
rtl/sample_playback_voice.sv
tb/tb_sample_playback_voice.sv
